// ----- hdl/frx_pkg.sv -----
// ----------------------------------------------------------------------------
// frx_pkg
// Shared codes, defaults and control/status bundles of the frame receiver.
// ----------------------------------------------------------------------------
package frx_pkg;

	localparam int FRX_BUFFER_DEPTH = 64;

	// command codes
	localparam logic [1:0] CMD_BYTE     = 2'd0;
	localparam logic [1:0] CMD_FETCH    = 2'd1;
	localparam logic [1:0] CMD_ENABLE   = 2'd2;
	localparam logic [1:0] CMD_RESERVED = 2'd3;

	// status codes
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_BUSY   = 2'd1;
	localparam logic [1:0] ST_DONE   = 2'd2;
	localparam logic [1:0] ST_LENERR = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic accept;     // request taken this cycle
		logic fetch_go;   // request is a fetch of a complete message
		logic stream;     // read one stored byte this cycle
		logic stream_end; // this read is the final byte
	} frx_ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic msg_done;   // a complete message is held
		logic rd_last;    // read pointer sits on the final byte
	} frx_stat_t;

endpackage

// ----- hdl/length_prefixed_frame_receiver_unit.sv -----
// A single result appears in the cycle after its request is accepted; the first
// streamed byte of a fetch passes the controller state register and then the
// read data register. Byte, enable and status requests go one per cycle while
// busy is low. A fetch of a complete message of length L streams L+1 bytes on
// consecutive cycles, one read of the message store each, busy high until the last.
// Reset: asynchronous, reception enabled, status idle, store contents undefined.
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver_unit
// Assembles length-prefixed messages from received bytes and streams them out.
// ----------------------------------------------------------------------------
module length_prefixed_frame_receiver_unit import frx_pkg::*; #(
	parameter int BUFFER_DEPTH = FRX_BUFFER_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] command,
	input  logic [7:0] rx_byte,
	output logic       result_valid,
	output logic [1:0] status,
	output logic [7:0] data_byte,
	output logic       data_valid,
	output logic       last,
	output logic       dropped
);

	frx_ctrl_t ctrl;
	frx_stat_t stat;

	frx_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.command(command),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	frx_datapath #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.command     (command),
		.rx_byte     (rx_byte),
		.stat        (stat),
		.result_valid(result_valid),
		.status      (status),
		.data_byte   (data_byte),
		.data_valid  (data_valid),
		.last        (last),
		.dropped     (dropped)
	);

endmodule

// ----- hdl/frx_ctrl.sv -----
// ----------------------------------------------------------------------------
// frx_ctrl
// Controller: accepts requests and sequences the fetch readout.
// ----------------------------------------------------------------------------
module frx_ctrl import frx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] command,
	input  frx_stat_t  stat,
	output frx_ctrl_t  ctrl,
	output logic       busy
);

	localparam logic S_IDLE   = 1'b0;
	localparam logic S_STREAM = 1'b1;

	logic state_q;
	logic state_d;

	assign busy = (state_q == S_STREAM);

	always_comb begin
		ctrl.accept     = start && !busy;
		ctrl.fetch_go   = ctrl.accept && (command == CMD_FETCH) && stat.msg_done;
		ctrl.stream     = busy;
		ctrl.stream_end = busy && stat.rd_last;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (ctrl.fetch_go)
					state_d = S_STREAM;
			end
			S_STREAM: begin
				if (stat.rd_last)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ----- hdl/frx_datapath.sv -----
// ----------------------------------------------------------------------------
// frx_datapath
// Message store, reception registers and result registers.
// ----------------------------------------------------------------------------
module frx_datapath import frx_pkg::*; #(
	parameter int BUFFER_DEPTH = FRX_BUFFER_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  frx_ctrl_t  ctrl,
	input  logic [1:0] command,
	input  logic [7:0] rx_byte,
	output frx_stat_t  stat,
	output logic       result_valid,
	output logic [1:0] status,
	output logic [7:0] data_byte,
	output logic       data_valid,
	output logic       last,
	output logic       dropped
);

	localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int IW = $clog2(BUFFER_DEPTH + 1);
	localparam logic [7:0]    DEPTH_B = 8'(BUFFER_DEPTH);
	localparam logic [IW-1:0] DEPTH_I = IW'(BUFFER_DEPTH);

	logic [7:0] mem [BUFFER_DEPTH];

	logic [IW-1:0] wr_idx_q, wr_idx_d;
	logic [AW-1:0] rem_q, rem_d;
	logic [AW-1:0] len_q, len_d;
	logic [AW-1:0] rd_q;
	logic          expect_q, expect_d;
	logic          en_q, en_d;
	logic [1:0]    rx_status_q, rx_status_d;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic          drop;

	logic       strobe_q;
	logic [1:0] status_q;
	logic [7:0] rdata_q;
	logic       valid_q;
	logic       last_q;
	logic       dropped_q;

	always_comb begin
		stat.msg_done = (rx_status_q == ST_DONE);
		stat.rd_last  = (rd_q == len_q);
	end

	// next reception state for a single-result request or the end of a readout
	always_comb begin
		wr_idx_d    = wr_idx_q;
		rem_d       = rem_q;
		len_d       = len_q;
		expect_d    = expect_q;
		en_d        = en_q;
		rx_status_d = rx_status_q;
		wr_en       = 1'b0;
		wr_addr     = wr_idx_q[AW-1:0];
		drop        = 1'b0;
		if (ctrl.accept && !ctrl.fetch_go) begin
			unique case (command)
				CMD_BYTE: begin
					if (!en_q) begin
						drop = 1'b1;
					end else if (expect_q) begin
						wr_idx_d = '0;
						if (rx_byte >= DEPTH_B) begin
							en_d        = 1'b0;
							rx_status_d = ST_LENERR;
						end else begin
							wr_en       = 1'b1;
							wr_addr     = '0;
							wr_idx_d    = IW'(1);
							len_d       = rx_byte[AW-1:0];
							rem_d       = rx_byte[AW-1:0];
							expect_d    = 1'b0;
							rx_status_d = ST_BUSY;
							// zero length completes at once
							if (rx_byte == 8'd0) begin
								en_d        = 1'b0;
								rx_status_d = ST_DONE;
								expect_d    = 1'b1;
							end
						end
					end else begin
						wr_en    = (wr_idx_q < DEPTH_I);
						wr_idx_d = wr_idx_q + IW'(1);
						rem_d    = rem_q - AW'(1);
						if (rem_q == AW'(1)) begin
							en_d        = 1'b0;
							rx_status_d = ST_DONE;
							expect_d    = 1'b1;
						end
					end
				end
				CMD_FETCH:    ;
				CMD_ENABLE:   en_d = 1'b1;
				CMD_RESERVED: ;
			endcase
		end
		// release the message after its final byte
		if (ctrl.stream_end) begin
			rx_status_d = ST_IDLE;
			wr_idx_d    = '0;
			expect_d    = 1'b1;
			en_d        = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q    <= '0;
			rem_q       <= '0;
			len_q       <= '0;
			expect_q    <= 1'b1;
			en_q        <= 1'b1;
			rx_status_q <= ST_IDLE;
		end else begin
			wr_idx_q    <= wr_idx_d;
			rem_q       <= rem_d;
			len_q       <= len_d;
			expect_q    <= expect_d;
			en_q        <= en_d;
			rx_status_q <= rx_status_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= rx_byte;
	end

	always_ff @(posedge clk) begin
		if (ctrl.stream)
			rdata_q <= mem[rd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_q <= '0;
		else if (ctrl.fetch_go)
			rd_q <= '0;
		else if (ctrl.stream)
			rd_q <= rd_q + AW'(1);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q  <= 1'b0;
			valid_q   <= 1'b0;
			status_q  <= ST_IDLE;
			last_q    <= 1'b0;
			dropped_q <= 1'b0;
		end else if (ctrl.stream) begin
			strobe_q  <= 1'b1;
			valid_q   <= 1'b1;
			status_q  <= ST_DONE;
			last_q    <= stat.rd_last;
			dropped_q <= 1'b0;
		end else if (ctrl.accept && !ctrl.fetch_go) begin
			strobe_q  <= 1'b1;
			valid_q   <= 1'b0;
			status_q  <= rx_status_d;
			last_q    <= 1'b1;
			dropped_q <= drop;
		end else begin
			strobe_q  <= 1'b0;
			valid_q   <= 1'b0;
		end
	end

	assign result_valid = strobe_q;
	assign status       = status_q;
	assign data_byte    = valid_q ? rdata_q : 8'd0;
	assign data_valid   = valid_q;
	assign last         = last_q;
	assign dropped      = dropped_q;

endmodule

// ----- hdl/frx_checker.sv -----
// ----------------------------------------------------------------------------
// frx_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module frx_checker import frx_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] command,
	input logic [7:0] rx_byte,
	input logic       result_valid,
	input logic [1:0] status,
	input logic [7:0] data_byte,
	input logic       data_valid,
	input logic       last,
	input logic       dropped
);

	// a taken request shows a result or a readout next cycle
	a_req_answered: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> result_valid || busy)
		else $error("request without answer");

	// a readout runs without gaps until its final byte
	a_stream_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |=> result_valid && data_valid)
		else $error("gap inside readout");

	// busy ends together with the final streamed byte
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_valid && data_valid && last)
		else $error("busy dropped without final byte");

	// streamed bytes always report a complete message
	a_stream_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && data_valid |-> status == ST_DONE && !dropped)
		else $error("streamed byte with wrong status");

endmodule

bind length_prefixed_frame_receiver_unit frx_checker u_frx_checker (.*);

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench of the length-prefixed frame receiver. Requests go in on the
// start/busy handshake, and a predictor of the receiver builds the responses
// each one should produce. Every result strobe is checked field by field
// against the oldest outstanding response. Directed tests cover idle
// requests, zero length, short messages, length errors and enables in the
// middle of a message. Random traffic follows, mostly well-formed messages
// with noise mixed in.
// ----------------------------------------------------------------------------
module tb import frx_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = FRX_BUFFER_DEPTH;
	localparam int AW          = $clog2(DEPTH);
	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_REQS = 500;

	typedef struct packed {
		logic [1:0] st;
		logic [7:0] data;
		logic       dv;
		logic       lst;
		logic       drp;
	} frx_out_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [1:0] command;
	logic [7:0] rx_byte;
	logic       result_valid;
	logic [1:0] status;
	logic [7:0] data_byte;
	logic       data_valid;
	logic       last;
	logic       dropped;

	// predictor state
	logic [7:0] msg_store [DEPTH];
	logic [6:0] wr_idx;
	logic [7:0] remaining;
	logic       want_len;
	logic [1:0] rx_st;
	logic       rx_on;

	frx_out_t   due_outputs [$];
	int         taken_reqs;
	int         cycles;
	bit         failed;
	bit         steady;

	length_prefixed_frame_receiver_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.rx_byte      (rx_byte),
		.result_valid (result_valid),
		.status       (status),
		.data_byte    (data_byte),
		.data_valid   (data_valid),
		.last         (last),
		.dropped      (dropped)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void queue_output(logic [1:0] st, logic [7:0] data, logic dv,
			logic lst, logic drp);
		frx_out_t r;
		r = '{st: st, data: data, dv: dv, lst: lst, drp: drp};
		due_outputs.push_back(r);
	endfunction

	function automatic void store_rx_byte(logic [7:0] b);
		if (wr_idx < DEPTH)
			msg_store[wr_idx[AW-1:0]] = b;
		wr_idx = wr_idx + 7'd1;
	endfunction

	function automatic void close_message();
		rx_on    = 1'b0;
		rx_st    = ST_DONE;
		want_len = 1'b1;
	endfunction

	// Work out the responses of one accepted request and update the state.
	function automatic void deframe_request(logic [1:0] cmd, logic [7:0] b);
		int len;
		case (cmd)
			CMD_BYTE: begin
				if (!rx_on) begin
					queue_output(rx_st, 8'd0, 1'b0, 1'b1, 1'b1);
				end else begin
					if (want_len) begin
						wr_idx = '0;
						if (b >= DEPTH) begin
							rx_on    = 1'b0;
							rx_st    = ST_LENERR;
							want_len = 1'b1;
						end else begin
							remaining = b;
							store_rx_byte(b);
							want_len = 1'b0;
							rx_st    = ST_BUSY;
							if (b == 8'd0)
								close_message();
						end
					end else begin
						store_rx_byte(b);
						remaining = remaining - 8'd1;
						if (remaining == 8'd0)
							close_message();
					end
					queue_output(rx_st, 8'd0, 1'b0, 1'b1, 1'b0);
				end
			end
			CMD_FETCH: begin
				if (rx_st != ST_DONE) begin
					queue_output(rx_st, 8'd0, 1'b0, 1'b1, 1'b0);
				end else begin
					len = msg_store[0];
					if (len >= DEPTH)
						len = DEPTH - 1;
					for (int i = 0; i <= len; i++)
						queue_output(ST_DONE, msg_store[i], 1'b1, (i == len), 1'b0);
					rx_st    = ST_IDLE;
					wr_idx   = '0;
					want_len = 1'b1;
					rx_on    = 1'b1;
				end
			end
			CMD_ENABLE: begin
				rx_on = 1'b1;
				queue_output(rx_st, 8'd0, 1'b0, 1'b1, 1'b0);
			end
			default: begin
				queue_output(rx_st, 8'd0, 1'b0, 1'b1, 1'b0);
			end
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 9);
		if (r < 6)
			return 0;
		if (r < 9)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// Drive one request at the falling edge and hold it until accepted.
	task automatic send_request(logic [1:0] cmd, logic [7:0] b);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			start = 1'b0;
		end
		@(negedge clk);
		start   = 1'b1;
		command = cmd;
		rx_byte = b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		deframe_request(cmd, b);
		taken_reqs++;
	endtask

	task automatic send_message(int len, logic [7:0] first_payload);
		send_request(CMD_BYTE, 8'(len));
		for (int i = 0; i < len; i++)
			send_request(CMD_BYTE, (i == 0) ? first_payload : 8'($urandom_range(0, 255)));
	endtask

	task automatic test_idle_requests();
		send_request(CMD_FETCH, 8'h00);
		send_request(CMD_RESERVED, 8'hFF);
		send_request(CMD_ENABLE, 8'h5A);
	endtask

	task automatic test_zero_length();
		send_request(CMD_BYTE, 8'h00);
		send_request(CMD_BYTE, 8'hFF);
		send_request(CMD_FETCH, 8'h00);
	endtask

	task automatic test_short_messages();
		send_request(CMD_BYTE, 8'd1);
		send_request(CMD_BYTE, 8'hFF);
		send_request(CMD_FETCH, 8'h00);
		send_request(CMD_BYTE, 8'd3);
		send_request(CMD_BYTE, 8'h00);
		send_request(CMD_BYTE, 8'hAA);
		send_request(CMD_BYTE, 8'h55);
		send_request(CMD_FETCH, 8'h00);
	endtask

	task automatic test_length_error();
		send_request(CMD_BYTE, 8'(DEPTH));
		send_request(CMD_BYTE, 8'd5);
		send_request(CMD_FETCH, 8'h00);
		send_request(CMD_ENABLE, 8'h00);
		send_request(CMD_BYTE, 8'hFF);
		send_request(CMD_ENABLE, 8'h00);
	endtask

	task automatic test_enable_midway();
		send_request(CMD_BYTE, 8'd2);
		send_request(CMD_BYTE, 8'h7F);
		send_request(CMD_ENABLE, 8'h00);
		send_request(CMD_BYTE, 8'h80);
		send_request(CMD_ENABLE, 8'h00);
		send_request(CMD_FETCH, 8'h00);
	endtask

	task automatic test_random_traffic();
		int pick;
		int len;
		while (taken_reqs < RANDOM_REQS) begin
			steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 7) begin
				// well-formed message with random content
				if (!rx_on || $urandom_range(0, 9) == 0)
					send_request(CMD_ENABLE, 8'($urandom_range(0, 255)));
				pick = $urandom_range(0, 19);
				if (pick == 0)
					len = 0;
				else if (pick == 1)
					len = DEPTH - 1;
				else if (pick < 4)
					len = $urandom_range(32, DEPTH - 2);
				else
					len = $urandom_range(1, 8);
				send_message(len, 8'($urandom_range(0, 255)));
				if ($urandom_range(0, 4) == 0)
					send_request(CMD_BYTE, 8'($urandom_range(0, 255)));
				if ($urandom_range(0, 9) != 0)
					send_request(CMD_FETCH, 8'($urandom_range(0, 255)));
			end else begin
				// noise and broken sequences
				repeat ($urandom_range(1, 6))
					send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end
		end
		steady = 1'b0;
	endtask

	function automatic void check_field(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
			failed = 1'b1;
		end
	endfunction

	always @(posedge clk) begin
		frx_out_t e;
		if (arst_n && result_valid) begin
			if (due_outputs.size() == 0) begin
				$error("unexpected result: status %0d data %0d", status, data_byte);
				failed = 1'b1;
			end else begin
				e = due_outputs.pop_front();
				check_field("status", e.st, status);
				check_field("data_byte", e.data, data_byte);
				check_field("data_valid", e.dv, data_valid);
				check_field("last", e.lst, last);
				check_field("dropped", e.drp, dropped);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL length_prefixed_frame_receiver_unit");
			$finish;
		end
	end

	initial begin
		arst_n  = 1'b0;
		start   = 1'b0;
		command = CMD_BYTE;
		rx_byte = 8'h00;
		failed  = 1'b0;
		steady  = 1'b0;
		cycles  = 0;
		wr_idx    = '0;
		remaining = '0;
		want_len  = 1'b1;
		rx_st     = ST_IDLE;
		rx_on     = 1'b1;
		taken_reqs = 0;
		for (int i = 0; i < DEPTH; i++)
			msg_store[i] = 8'h00;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_requests();
		test_zero_length();
		test_short_messages();
		test_length_error();
		test_enable_midway();
		test_random_traffic();

		@(negedge clk);
		start = 1'b0;
		while (due_outputs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (!failed)
			$display("PASS length_prefixed_frame_receiver_unit");
		else
			$display("FAIL length_prefixed_frame_receiver_unit");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/frx_pkg.sv
hdl/frx_ctrl.sv
hdl/frx_datapath.sv
hdl/length_prefixed_frame_receiver_unit.sv
hdl/frx_checker.sv
test/tb.sv
